@@ rtl/core/lowest_free_slot_timed_release_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the lowest free slot timed release unit
// Shared clocked assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_SLOT_TIMED_RELEASE_UNIT_DEFINES_SVH
`define LOWEST_FREE_SLOT_TIMED_RELEASE_UNIT_DEFINES_SVH

// Checked on every rising edge once reset has been released.
`define LFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lfs checker: property failed");

// Checked on every rising edge, also while reset is asserted.
`define LFS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lfs checker: property failed");

`endif

@@ rtl/core/lfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Lowest free slot unit package
// Field widths and the control record that travels along the cell chain.
// ----------------------------------------------------------------------------
package lfs_pkg;

  // Widths of the request and result fields.
  localparam int unsigned TIME_FIELD_W = 32;
  localparam int unsigned SLOT_W       = 5;

  // Control record handed from one cell to the next.
  typedef struct packed {
    logic valid;
    logic granted;
  } lfs_ctl_t;

endpackage

@@ rtl/core/lfs_intf.sv @@
// ----------------------------------------------------------------------------
// Lowest free slot unit channel interfaces
// Request channel (arrival, leave) and result channel (slot, full flag).
// ----------------------------------------------------------------------------
interface lfs_req_if;
  import lfs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TIME_FIELD_W-1:0] arrival_time;
  logic [TIME_FIELD_W-1:0] leave_time;

  modport source (output valid, output arrival_time, output leave_time, input ready);
  modport sink   (input valid, input arrival_time, input leave_time, output ready);
endinterface

interface lfs_res_if;
  import lfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              full_res;

  modport source (output valid, output slot, output full_res, input ready);
  modport sink   (input valid, input slot, input full_res, output ready);
endinterface

@@ rtl/core/lfs_cell.sv @@
// ----------------------------------------------------------------------------
// Lowest free slot cell
// Holds one slot and one pipeline stage of the request chain.
// ----------------------------------------------------------------------------
module lfs_cell #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned IDX_W     = 5,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  lfs_pkg::lfs_ctl_t    ctl_i,
  input  logic [TIME_BITS-1:0] arrive_i,
  input  logic [TIME_BITS-1:0] leave_i,
  input  logic [IDX_W-1:0]     slot_i,
  output lfs_pkg::lfs_ctl_t    ctl_o,
  output logic [TIME_BITS-1:0] arrive_o,
  output logic [TIME_BITS-1:0] leave_o,
  output logic [IDX_W-1:0]     slot_o
);
  import lfs_pkg::*;

  logic                 occ_q, occ_d;
  logic [TIME_BITS-1:0] rel_q, rel_d;
  logic                 free;
  logic                 grant;
  lfs_ctl_t             ctl_q, ctl_d;
  logic [TIME_BITS-1:0] arrive_q, leave_q;
  logic [IDX_W-1:0]     slot_q, slot_d;

  // The slot is free if it is empty or its release time has come.
  always_comb begin
    free  = !occ_q || (rel_q <= arrive_i);
    grant = ctl_i.valid && !ctl_i.granted && free;
  end

  // Release first, then take the slot if no lower cell granted one.
  always_comb begin
    occ_d = occ_q;
    rel_d = rel_q;
    if (ctl_i.valid) begin
      if (free) begin
        occ_d = 1'b0;
      end
      if (grant) begin
        occ_d = 1'b1;
        rel_d = leave_i;
      end
    end
  end

  // Request record passed to the next cell.
  always_comb begin
    ctl_d.valid   = ctl_i.valid;
    ctl_d.granted = ctl_i.granted || grant;
    slot_d        = grant ? IDX_W'(CELL_IDX) : slot_i;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      ctl_q <= '0;
    end else if (adv_i) begin
      occ_q <= occ_d;
      ctl_q <= ctl_d;
    end
  end

  // Payload state.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rel_q    <= rel_d;
      arrive_q <= arrive_i;
      leave_q  <= leave_i;
      slot_q   <= slot_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign arrive_o = arrive_q;
  assign leave_o  = leave_q;
  assign slot_o   = slot_q;

endmodule

@@ rtl/core/lowest_free_slot_timed_release_unit.sv @@
// ----------------------------------------------------------------------------
// Lowest free slot timed release unit
// Requests pass through one cell stage per slot from acceptance to the result.
// Throughput: one request per cycle while the result side takes results.
// A stalled result holds the whole cell chain, and then no request is accepted.
// Reset clears every slot to free at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module lowest_free_slot_timed_release_unit #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lfs_req_if.sink      req_i,
  lfs_res_if.source    res_o
);
  import lfs_pkg::*;

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  lfs_ctl_t             ctl_chain  [NUM_SLOTS+1];
  logic [IDX_W-1:0]     slot_chain [NUM_SLOTS+1];
  logic [TIME_BITS-1:0] arr_chain  [NUM_SLOTS];
  logic [TIME_BITS-1:0] lv_chain   [NUM_SLOTS];
  logic                 adv;

  // The chain moves when the result register is empty or being taken.
  assign adv         = !ctl_chain[NUM_SLOTS].valid || res_o.ready;
  assign req_i.ready = adv;

  // Chain entry from the request channel.
  assign ctl_chain[0].valid   = req_i.valid;
  assign ctl_chain[0].granted = 1'b0;
  assign slot_chain[0]        = '0;
  assign arr_chain[0]         = TIME_BITS'(req_i.arrival_time);
  assign lv_chain[0]          = TIME_BITS'(req_i.leave_time);

  // One cell per slot; the last cell's stage is the result register.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    if (g < NUM_SLOTS - 1) begin : g_mid
      lfs_cell #(
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W),
        .CELL_IDX  (g)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .adv_i    (adv),
        .ctl_i    (ctl_chain[g]),
        .arrive_i (arr_chain[g]),
        .leave_i  (lv_chain[g]),
        .slot_i   (slot_chain[g]),
        .ctl_o    (ctl_chain[g+1]),
        .arrive_o (arr_chain[g+1]),
        .leave_o  (lv_chain[g+1]),
        .slot_o   (slot_chain[g+1])
      );
    end else begin : g_last
      lfs_cell #(
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W),
        .CELL_IDX  (g)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .adv_i    (adv),
        .ctl_i    (ctl_chain[g]),
        .arrive_i (arr_chain[g]),
        .leave_i  (lv_chain[g]),
        .slot_i   (slot_chain[g]),
        .ctl_o    (ctl_chain[g+1]),
        .arrive_o (),
        .leave_o  (),
        .slot_o   (slot_chain[g+1])
      );
    end
  end

  // Result channel; a request that found no free slot reports full.
  assign res_o.valid    = ctl_chain[NUM_SLOTS].valid;
  assign res_o.full_res = !ctl_chain[NUM_SLOTS].granted;
  assign res_o.slot     = ctl_chain[NUM_SLOTS].granted ?
                          SLOT_W'(slot_chain[NUM_SLOTS]) : '0;

endmodule

@@ rtl/core/lfs_checker.sv @@
// ----------------------------------------------------------------------------
// Lowest free slot unit port checker
// Watches the top-level channels and is bound to the top level.
// ----------------------------------------------------------------------------
`include "lowest_free_slot_timed_release_unit_defines.svh"

module lfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] out_slot_i,
  input logic       out_full_i
);

  // A waiting result keeps its fields.
  `LFS_ASSERT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_slot_i) && $stable(out_full_i))

  // A full result never carries a slot number.
  `LFS_ASSERT(a_full_slot_zero, clk_i, rst_ni, out_valid_i && out_full_i |-> out_slot_i == 5'd0)

  // A stalled result holds the chain, so no request is taken.
  `LFS_ASSERT(a_stall_blocks_req, clk_i, rst_ni, out_valid_i && !out_ready_i |-> !in_ready_i)

  // No result is shown while reset is asserted.
  `LFS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i)

  // A free result register always lets a request in.
  `LFS_ASSERT(a_empty_takes_req, clk_i, rst_ni, !out_valid_i && in_valid_i |-> in_ready_i)

endmodule

bind lowest_free_slot_timed_release_unit lfs_checker u_lfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_slot_i  (res_o.slot),
  .out_full_i  (res_o.full_res)
);
